FILE: sv/dcds_pkg.sv
// Package of types, constants and helpers shared by the donor-cell stencil block.
`default_nettype none
package dcds_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 10;
  localparam int GAMMA_W  = 18;
  localparam int DW       = 52;
  localparam int BW       = 33;
  localparam int PW       = DW + BW;
  localparam int ADDR_W   = 5;

  localparam logic [2:0] REG_INV_DX    = 3'd0;
  localparam logic [2:0] REG_INV_DY    = 3'd1;
  localparam logic [2:0] REG_INV_DX_SQ = 3'd2;
  localparam logic [2:0] REG_INV_DY_SQ = 3'd3;
  localparam logic [2:0] REG_GAMMA     = 3'd4;
  localparam logic [2:0] REG_ROWS      = 3'd5;
  localparam logic [2:0] REG_COLS      = 3'd6;

  localparam logic [2:0] TERM_LAST = 3'd7;

  typedef enum logic [2:0] {
    OP_Q0, OP_Q1, OP_Q2, OP_Q3, OP_GAM, OP_SCL
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_START, ST_MUL, ST_POST, ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u_sample;
    logic signed [SAMPLE_W-1:0] v_sample;
    logic                       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]           center_row;
    logic [COL_W-1:0]           center_col;
    logic                       u_terms_valid;
    logic                       v_terms_valid;
    logic signed [SAMPLE_W-1:0] u_xx;
    logic signed [SAMPLE_W-1:0] u_yy;
    logic signed [SAMPLE_W-1:0] uu_x;
    logic signed [SAMPLE_W-1:0] uv_y;
    logic signed [SAMPLE_W-1:0] v_xx;
    logic signed [SAMPLE_W-1:0] v_yy;
    logic signed [SAMPLE_W-1:0] uv_x;
    logic signed [SAMPLE_W-1:0] vv_y;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        inv_dx;
    logic [31:0]        inv_dy;
    logic [31:0]        inv_dx_sq;
    logic [31:0]        inv_dy_sq;
    logic [GAMMA_W-1:0] upwind_weight;
    logic [ROW_W-1:0]   interior_rows;
    logic [COL_W-1:0]   interior_cols;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       win_load;
    logic       mul_start;
    logic       post_en;
    logic       out_load;
    op_t        op;
    logic [2:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic uok;
    logic vok;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  function automatic op_t op_after(input op_t op);
    case (op)
      OP_Q0:   op_after = OP_Q1;
      OP_Q1:   op_after = OP_Q2;
      OP_Q2:   op_after = OP_Q3;
      OP_Q3:   op_after = OP_GAM;
      default: op_after = OP_SCL;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/dcds_mul.sv
// Shift-and-add multiplier that takes one bit of the second operand per cycle.
`default_nettype none
module dcds_mul import dcds_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [PW-1:0] p
);

  localparam int CNT_W = $clog2(BW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    a_r, a_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [PW-1:0]    p_r, p_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = PW'(a);
      b_nxt    = b;
      p_nxt    = '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

FILE: sv/dcds_ctrl.sv
// Controller state machine that sequences capture, window update and term evaluation.
`default_nettype none
module dcds_ctrl import dcds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] term_r, term_nxt;
  op_t        op_r, op_nxt;
  logic       term_ok;
  state_t     adv_state;
  logic [2:0] adv_term;
  op_t        adv_op;

  assign term_ok = term_r[2] ? status.vok : status.uok;

  always_comb begin
    adv_term  = term_r + 3'd1;
    adv_state = (term_r == TERM_LAST) ? ST_EMIT : ST_START;
    adv_op    = adv_term[1] ? OP_Q0 : OP_SCL;
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        term_nxt  = '0;
        op_nxt    = OP_SCL;
        state_nxt = status.emit ? ST_START : ST_IDLE;
      end
      ST_START: begin
        if (term_ok) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = adv_state;
          term_nxt  = adv_term;
          op_nxt    = adv_op;
        end
      end
      ST_MUL: begin
        if (status.mul_done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (op_r == OP_SCL) begin
          state_nxt = adv_state;
          term_nxt  = adv_term;
          op_nxt    = adv_op;
        end else begin
          state_nxt = ST_START;
          op_nxt    = op_after(op_r);
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.term      = term_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_READ:  cmd.win_load  = 1'b1;
      ST_START: cmd.mul_start = term_ok;
      ST_POST:  cmd.post_en   = 1'b1;
      ST_EMIT:  cmd.out_load  = !status.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      term_r  <= '0;
      op_r    <= OP_SCL;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/dcds_datapath.sv
// Datapath with raster counters, line stores, stencil windows, term arithmetic and result register.
`default_nettype none
module dcds_datapath import dcds_pkg::*; #(
  parameter int MAX_ROW_LEN = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int IDX_W = $clog2(MAX_ROW_LEN);
  localparam int CMAX  = (MAX_ROW_LEN - 2 < 1022) ? MAX_ROW_LEN - 2 : 1022;
  localparam logic [PW-1:0] GCAP = PW'(64'd1 << 50);
  localparam logic [PW-1:0] SCAP = PW'(64'd1 << 32);
  localparam logic [32:0]   SLIM = 33'd1 << 31;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] rows_c;
  logic [COL_W-1:0] cols_c;
  logic [COL_W:0]   len;
  logic [ROW_W:0]   rlim, r1, r, r_inc;
  logic [COL_W-1:0] c1, c;
  logic [COL_W:0]   c_inc;
  logic [IDX_W-1:0] cidx;
  logic             emit, uok, vok;

  always_comb begin
    rows_c = (cfg.interior_rows < ROW_W'(2)) ? ROW_W'(2) :
             (cfg.interior_rows > ROW_W'(65533)) ? ROW_W'(65533) : cfg.interior_rows;
    cols_c = (cfg.interior_cols < COL_W'(2)) ? COL_W'(2) :
             (cfg.interior_cols > COL_W'(CMAX)) ? COL_W'(CMAX) : cfg.interior_cols;
    len  = {1'b0, cols_c} + (COL_W + 1)'(2);
    rlim = {1'b0, rows_c} + (ROW_W + 1)'(2);
    if (in_data.frame_start) begin
      r1 = '0;
      c1 = '0;
    end else if ({1'b0, col_r} >= len) begin
      r1 = {1'b0, row_r} + (ROW_W + 1)'(1);
      c1 = '0;
    end else begin
      r1 = {1'b0, row_r};
      c1 = col_r;
    end
    r     = (r1 >= rlim) ? '0 : r1;
    c     = (32'(c1) >= MAX_ROW_LEN) ? '0 : c1;
    cidx  = IDX_W'(c);
    c_inc = {1'b0, c} + (COL_W + 1)'(1);
    r_inc = r + (ROW_W + 1)'(1);
    if (c_inc >= len) begin
      col_nxt = '0;
      row_nxt = (r_inc >= rlim) ? '0 : ROW_W'(r_inc);
    end else begin
      col_nxt = COL_W'(c_inc);
      row_nxt = ROW_W'(r);
    end
    emit = (r >= (ROW_W + 1)'(2)) && (r <= {1'b0, rows_c} + (ROW_W + 1)'(1)) &&
           (c >= COL_W'(2)) && ({1'b0, c} <= {1'b0, cols_c} + (COL_W + 1)'(1));
    uok  = (ROW_W'(r) - ROW_W'(1)) < rows_c;
    vok  = (c - COL_W'(1)) < cols_c;
  end

  logic signed [SAMPLE_W-1:0] u_in_r, v_in_r;
  logic [IDX_W-1:0]           cidx_r;
  logic [ROW_W-1:0]           crow_r;
  logic [COL_W-1:0]           ccol_r;
  logic                       emit_r, uok_r, vok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      emit_r <= 1'b0;
      uok_r  <= 1'b0;
      vok_r  <= 1'b0;
    end else if (cmd.capture) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      emit_r <= emit;
      uok_r  <= uok;
      vok_r  <= vok;
    end
    if (cmd.capture) begin
      u_in_r <= in_data.u_sample;
      v_in_r <= in_data.v_sample;
      cidx_r <= cidx;
      crow_r <= ROW_W'(r) - ROW_W'(1);
      ccol_r <= c - COL_W'(1);
    end
  end

  logic [2*SAMPLE_W-1:0] line0_mem [MAX_ROW_LEN];
  logic [2*SAMPLE_W-1:0] line1_mem [MAX_ROW_LEN];
  logic [2*SAMPLE_W-1:0] rd0_r, rd1_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd0_r <= line0_mem[cidx];
    end
    if (cmd.win_load) begin
      line0_mem[cidx_r] <= {u_in_r, v_in_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd1_r <= line1_mem[cidx];
    end
    if (cmd.win_load) begin
      line1_mem[cidx_r] <= rd0_r;
    end
  end

  logic signed [SAMPLE_W-1:0] uw_r [9];
  logic signed [SAMPLE_W-1:0] vw_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        uw_r[k] <= '0;
        vw_r[k] <= '0;
      end
    end else if (cmd.win_load) begin
      for (int k = 0; k < 3; k++) begin
        uw_r[k*3]   <= uw_r[k*3+1];
        uw_r[k*3+1] <= uw_r[k*3+2];
        vw_r[k*3]   <= vw_r[k*3+1];
        vw_r[k*3+1] <= vw_r[k*3+2];
      end
      uw_r[2] <= rd1_r[2*SAMPLE_W-1:SAMPLE_W];
      vw_r[2] <= rd1_r[SAMPLE_W-1:0];
      uw_r[5] <= rd0_r[2*SAMPLE_W-1:SAMPLE_W];
      vw_r[5] <= rd0_r[SAMPLE_W-1:0];
      uw_r[8] <= u_in_r;
      vw_r[8] <= v_in_r;
    end
  end

  function automatic logic signed [DW-1:0] add_w(input logic signed [SAMPLE_W-1:0] x,
                                                  input logic signed [SAMPLE_W-1:0] y);
    add_w = DW'(x) + DW'(y);
  endfunction

  function automatic logic signed [DW-1:0] sub_w(input logic signed [SAMPLE_W-1:0] x,
                                                  input logic signed [SAMPLE_W-1:0] y);
    sub_w = DW'(x) - DW'(y);
  endfunction

  logic signed [DW-1:0] ta, tb, tc, td, te, tf, ts;
  logic signed [SAMPLE_W-1:0] w1, w3, w4, w5, w7;

  always_comb begin
    w1 = cmd.term[2] ? vw_r[1] : uw_r[1];
    w3 = cmd.term[2] ? vw_r[3] : uw_r[3];
    w4 = cmd.term[2] ? vw_r[4] : uw_r[4];
    w5 = cmd.term[2] ? vw_r[5] : uw_r[5];
    w7 = cmd.term[2] ? vw_r[7] : uw_r[7];
    if (cmd.term[0]) begin
      ts = DW'(w5) - (DW'(w4) <<< 1) + DW'(w3);
    end else begin
      ts = DW'(w7) - (DW'(w4) <<< 1) + DW'(w1);
    end
    case (cmd.term)
      3'd3: begin
        ta = add_w(vw_r[4], vw_r[7]);
        tc = add_w(uw_r[4], uw_r[5]);
        tb = add_w(vw_r[3], vw_r[6]);
        td = add_w(uw_r[3], uw_r[4]);
        te = sub_w(uw_r[4], uw_r[5]);
        tf = sub_w(uw_r[3], uw_r[4]);
      end
      3'd6: begin
        ta = add_w(uw_r[4], uw_r[5]);
        tc = add_w(vw_r[4], vw_r[7]);
        tb = add_w(uw_r[1], uw_r[2]);
        td = add_w(vw_r[1], vw_r[4]);
        te = sub_w(vw_r[4], vw_r[7]);
        tf = sub_w(vw_r[1], vw_r[4]);
      end
      3'd7: begin
        ta = add_w(vw_r[4], vw_r[5]);
        tc = ta;
        tb = add_w(vw_r[3], vw_r[4]);
        td = tb;
        te = sub_w(vw_r[4], vw_r[5]);
        tf = sub_w(vw_r[3], vw_r[4]);
      end
      default: begin
        ta = add_w(uw_r[4], uw_r[7]);
        tc = ta;
        tb = add_w(uw_r[1], uw_r[4]);
        td = tb;
        te = sub_w(uw_r[4], uw_r[7]);
        tf = sub_w(uw_r[1], uw_r[4]);
      end
    endcase
  end

  logic signed [DW-1:0] d1_r, d2_r;
  logic                 neg_r;
  logic signed [DW-1:0] xs, ys;
  logic [DW-1:0]        mul_a;
  logic [BW-1:0]        mul_b;
  logic                 mul_neg;
  logic                 mul_done;
  logic [PW-1:0]        mul_p;

  always_comb begin
    xs      = '0;
    ys      = '0;
    mul_neg = 1'b0;
    mul_b   = '0;
    case (cmd.op)
      OP_Q0: begin
        xs = ta;
        ys = tc;
        mul_neg = xs[DW-1] ^ ys[DW-1];
        mul_b   = BW'(mag(ys));
      end
      OP_Q1: begin
        xs = tb;
        ys = td;
        mul_neg = xs[DW-1] ^ ys[DW-1];
        mul_b   = BW'(mag(ys));
      end
      OP_Q2: begin
        xs = ta;
        ys = te;
        mul_neg = ys[DW-1];
        mul_b   = BW'(mag(ys));
      end
      OP_Q3: begin
        xs = tb;
        ys = tf;
        mul_neg = ys[DW-1];
        mul_b   = BW'(mag(ys));
      end
      OP_GAM: begin
        xs = d2_r;
        mul_neg = xs[DW-1];
        mul_b   = BW'(cfg.upwind_weight);
      end
      OP_SCL: begin
        if (cmd.term[1]) begin
          xs    = d1_r;
          mul_b = BW'(cmd.term[0] ? cfg.inv_dy : cfg.inv_dx);
        end else begin
          xs    = ts;
          mul_b = BW'(cmd.term[0] ? cfg.inv_dy_sq : cfg.inv_dx_sq);
        end
        mul_neg = xs[DW-1];
      end
      default: begin
        xs = '0;
      end
    endcase
    mul_a = mag(xs);
  end

  dcds_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  logic [PW-1:0]        q_sum, r_sum, r_sh;
  logic signed [DW-1:0] q_val, g_mag;
  logic [32:0]          s_mag;
  logic signed [SAMPLE_W-1:0] s_res;

  always_comb begin
    q_sum = mul_p + PW'(1 << 17);
    q_val = neg_r ? -DW'(q_sum >> 18) : DW'(q_sum >> 18);
    r_sum = mul_p + PW'(1 << 15);
    r_sh  = r_sum >> 16;
    g_mag = (r_sh > GCAP) ? DW'(GCAP) : DW'(r_sh);
    s_mag = (r_sh > SCAP) ? 33'(SCAP) : 33'(r_sh);
    if (!neg_r) begin
      s_res = (s_mag >= SLIM) ? 32'sh7FFF_FFFF : SAMPLE_W'(s_mag);
    end else begin
      s_res = (s_mag >= SLIM) ? 32'sh8000_0000 : -SAMPLE_W'(s_mag);
    end
  end

  logic signed [SAMPLE_W-1:0] res_r [8];

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      neg_r <= mul_neg;
    end
    if (cmd.win_load) begin
      for (int k = 0; k < 8; k++) begin
        res_r[k] <= '0;
      end
    end
    if (cmd.post_en) begin
      case (cmd.op)
        OP_Q0:  d1_r <= q_val;
        OP_Q1:  d1_r <= d1_r - q_val;
        OP_Q2:  d2_r <= q_val;
        OP_Q3:  d2_r <= d2_r - q_val;
        OP_GAM: d1_r <= neg_r ? d1_r - g_mag : d1_r + g_mag;
        OP_SCL: res_r[cmd.term] <= s_res;
        default: d1_r <= d1_r;
      endcase
    end
  end

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r.center_row    <= crow_r;
      out_data_r.center_col    <= ccol_r;
      out_data_r.u_terms_valid <= uok_r;
      out_data_r.v_terms_valid <= vok_r;
      out_data_r.u_xx          <= res_r[0];
      out_data_r.u_yy          <= res_r[1];
      out_data_r.uu_x          <= res_r[2];
      out_data_r.uv_y          <= res_r[3];
      out_data_r.v_xx          <= res_r[4];
      out_data_r.v_yy          <= res_r[5];
      out_data_r.uv_x          <= res_r[6];
      out_data_r.vv_y          <= res_r[7];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.emit     = emit_r;
  assign status.uok      = uok_r;
  assign status.vok      = vok_r;
  assign status.mul_done = mul_done;
  assign status.out_busy = out_valid_r && !out_ready;

endmodule
`default_nettype wire

FILE: sv/donor_cell_derivative_stencil_unit.sv
// Top level of the donor-cell derivative stencil: register port, controller and datapath.
//
//  Channel  Direction  Handshake                    Payload
//  in_      input      in_valid / in_ready          in_data (in_item_t)
//  out_     output     out_valid / out_ready        out_data (out_item_t)
//  cfg      input      psel, penable, pwrite, ...   paddr, pwdata, prdata
//
// An item that completes no interior centre is captured, loads the windows and returns to idle.
// An item that completes one runs its products one after another on the shared shift-and-add
// multiplier: six products for each convective term and one for each second derivative.
// Reset clears the counters, windows, controller and output valid; line stores are not cleared.
// A finished result waits in the output register while the next item is taken in.
`default_nettype none
module donor_cell_derivative_stencil_unit import dcds_pkg::*; #(
  parameter int MAX_ROW_LEN = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  logic       cfg_we;
  logic [2:0] cfg_sel;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_dx        <= 32'd65536;
      cfg_r.inv_dy        <= 32'd65536;
      cfg_r.inv_dx_sq     <= 32'd65536;
      cfg_r.inv_dy_sq     <= 32'd65536;
      cfg_r.upwind_weight <= '0;
      cfg_r.interior_rows <= ROW_W'(2);
      cfg_r.interior_cols <= COL_W'(2);
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_INV_DX:    cfg_r.inv_dx        <= pwdata;
        REG_INV_DY:    cfg_r.inv_dy        <= pwdata;
        REG_INV_DX_SQ: cfg_r.inv_dx_sq     <= pwdata;
        REG_INV_DY_SQ: cfg_r.inv_dy_sq     <= pwdata;
        REG_GAMMA:     cfg_r.upwind_weight <= pwdata[GAMMA_W-1:0];
        REG_ROWS:      cfg_r.interior_rows <= pwdata[ROW_W-1:0];
        REG_COLS:      cfg_r.interior_cols <= pwdata[COL_W-1:0];
        default:       cfg_r               <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_INV_DX:    prdata = cfg_r.inv_dx;
      REG_INV_DY:    prdata = cfg_r.inv_dy;
      REG_INV_DX_SQ: prdata = cfg_r.inv_dx_sq;
      REG_INV_DY_SQ: prdata = cfg_r.inv_dy_sq;
      REG_GAMMA:     prdata = 32'(cfg_r.upwind_weight);
      REG_ROWS:      prdata = 32'(cfg_r.interior_rows);
      REG_COLS:      prdata = 32'(cfg_r.interior_cols);
      default:       prdata = '0;
    endcase
  end

  dcds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dcds_datapath #(
    .MAX_ROW_LEN (MAX_ROW_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second item was taken while one was still in the datapath.");

  a_u_terms_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.u_terms_valid) |->
      (out_data.u_xx == 0 && out_data.u_yy == 0 && out_data.uu_x == 0 && out_data.uv_y == 0))
    else $error("The u terms of a result are not zero although they are marked invalid.");

  a_v_terms_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.v_terms_valid) |->
      (out_data.v_xx == 0 && out_data.v_yy == 0 && out_data.uv_x == 0 && out_data.vv_y == 0))
    else $error("The v terms of a result are not zero although they are marked invalid.");

endmodule
`default_nettype wire
